// ----- src/rti_pkg.sv -----
// Package for the ray/triangle intersection block: widths, register codes, arithmetic helpers.
package rti_pkg;

    // Coordinate and fraction widths of the Q16.16 fields.
    localparam int CW     = 32;
    localparam int FRAC_W = 16;
    localparam int BARY_W = 16;
    localparam int IDW    = 16;
    localparam int TW     = 32;

    // Derived datapath widths.
    localparam int EW  = CW + 1;            // edges and origin offset
    localparam int XW  = 2 * EW + 1;        // cross products
    localparam int LW  = EW;                // low slice of a cross product
    localparam int HW  = XW - LW;           // high slice, signed
    localparam int PW2 = EW + HW;           // one partial product
    localparam int DW  = EW + XW + 2;       // dot products
    localparam int NW  = DW + TW + 1;       // offset numerator of t
    localparam int RW  = DW + 1;            // divider remainder
    localparam int UQ  = BARY_W + 1;        // barycentric quotient bits

    localparam int IDATA_W = ((IDW + 9 * CW + 7) / 8) * 8;
    localparam int ODATA_W = ((IDW + TW + 2 * UQ + 7) / 8) * 8;

    localparam int REG_IW = 3;
    localparam int REG_W  = 32;

    localparam logic signed [CW-1:0] DIR_Z_RST = CW'(65536);
    localparam logic signed [CW-1:0] TFAR_RST  = CW'(32'h7FFF_FFFF);
    localparam logic signed [TW-1:0] T_MAX     = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN     = {1'b1, {(TW-1){1'b0}}};

    typedef enum logic [REG_IW-1:0] {
        REG_ORG_X  = 3'd0,
        REG_ORG_Y  = 3'd1,
        REG_ORG_Z  = 3'd2,
        REG_DIR_X  = 3'd3,
        REG_DIR_Y  = 3'd4,
        REG_DIR_Z  = 3'd5,
        REG_T_NEAR = 3'd6,
        REG_T_FAR  = 3'd7
    } t_reg_idx;

    // One stage of the divider pipeline.
    typedef struct packed {
        logic [IDW-1:0] id;
        logic           bary_ok;
        logic           sat_lo;
        logic           sat_hi;
        logic [DW-1:0]  det;
        logic [RW-1:0]  tr;
        logic [TW-1:0]  tl;
        logic [RW-1:0]  ur;
        logic [UQ-1:0]  ul;
        logic [RW-1:0]  vr;
        logic [UQ-1:0]  vl;
    } t_dv;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic          q;
    } t_step;

    function automatic logic signed [2*EW-1:0] smul_e(input logic signed [EW-1:0] a,
                                                      input logic signed [EW-1:0] b);
        smul_e = (2*EW)'(a) * (2*EW)'(b);
    endfunction

    function automatic logic signed [PW2-1:0] smul_h(input logic signed [EW-1:0] a,
                                                     input logic signed [HW-1:0] b);
        smul_h = PW2'(a) * PW2'(b);
    endfunction

    // One restoring division step: shift in a bit, subtract the divisor if it fits.
    function automatic t_step div_step(input logic [RW-1:0] rem, input logic nb,
                                       input logic [DW-1:0] den);
        logic [RW-1:0] x;
        t_step         s;
        x = {rem[RW-2:0], nb};
        if (x >= RW'(den)) begin
            s.rem = x - RW'(den);
            s.q   = 1'b1;
        end else begin
            s.rem = x;
            s.q   = 1'b0;
        end
        return s;
    endfunction

endpackage

// ----- src/ray_triangle_intersect.sv -----
// Pipelined Moller-Trumbore ray/triangle intersection for one configured ray.
// The pipe holds 42 register stages from an accepted item to its result.
// Throughput: one triangle item per cycle; a stalled output freezes the whole pipe.
// The pipe is 9 arithmetic stages, a 32-stage restoring divider and an output register.
// Reset (synchronous, active low) clears all valid bits and loads the default ray.
// Configuration is applied immediately and must only change while the pipe is empty.
module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [REG_IW-1:0]    i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    // Triangle items.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IDATA_W-1:0]   i_s_tdata,   // tri_id, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    // Result items.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [ODATA_W-1:0]   o_m_tdata,   // tri_id_out, hit_t, bary_u, bary_v, zero pad
    output logic                 o_m_tuser    // hit
);

    // ------------------------------------------------------------------
    // Ray registers.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_org [0:2];
    logic signed [CW-1:0] r_dir [0:2];
    logic signed [CW-1:0] r_tnear;
    logic signed [CW-1:0] r_tfar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= DIR_Z_RST;
            r_tnear  <= '0;
            r_tfar   <= TFAR_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ORG_X:  r_org[0] <= CW'(i_cfg_data);
                REG_ORG_Y:  r_org[1] <= CW'(i_cfg_data);
                REG_ORG_Z:  r_org[2] <= CW'(i_cfg_data);
                REG_DIR_X:  r_dir[0] <= CW'(i_cfg_data);
                REG_DIR_Y:  r_dir[1] <= CW'(i_cfg_data);
                REG_DIR_Z:  r_dir[2] <= CW'(i_cfg_data);
                REG_T_NEAR: r_tnear  <= CW'(i_cfg_data);
                REG_T_FAR:  r_tfar   <= CW'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // The whole pipe advances together whenever the output register can move.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: edges E1 = B - A, E2 = C - A and origin offset T = O - A.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_a [0:2];
    logic signed [CW-1:0] w_b [0:2];
    logic signed [CW-1:0] w_c [0:2];
    logic signed [EW-1:0] w_dx [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i]  = i_s_tdata[IDW + CW*i       +: CW];
            w_b[i]  = i_s_tdata[IDW + CW*(i + 3) +: CW];
            w_c[i]  = i_s_tdata[IDW + CW*(i + 6) +: CW];
            w_dx[i] = EW'(r_dir[i]);
        end
    end

    logic                 r1_v;
    logic [IDW-1:0]       r1_id;
    logic signed [EW-1:0] r1_e1 [0:2];
    logic signed [EW-1:0] r1_e2 [0:2];
    logic signed [EW-1:0] r1_t  [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_id <= i_s_tdata[IDW-1:0];
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= EW'(w_b[i]) - EW'(w_a[i]);
                r1_e2[i] <= EW'(w_c[i]) - EW'(w_a[i]);
                r1_t[i]  <= EW'(r_org[i]) - EW'(w_a[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the twelve products of P = D x E2 and Q = T x E1.
    // Entry 2k is the positive term and entry 2k+1 the negative term of component k.
    // ------------------------------------------------------------------
    logic                   r2_v;
    logic [IDW-1:0]         r2_id;
    logic signed [EW-1:0]   r2_e1 [0:2];
    logic signed [EW-1:0]   r2_e2 [0:2];
    logic signed [EW-1:0]   r2_t  [0:2];
    logic signed [2*EW-1:0] r2_pm [0:5];
    logic signed [2*EW-1:0] r2_qm [0:5];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_id <= r1_id;
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_t  <= r1_t;
            r2_pm[0] <= smul_e(w_dx[1], r1_e2[2]);
            r2_pm[1] <= smul_e(w_dx[2], r1_e2[1]);
            r2_pm[2] <= smul_e(w_dx[2], r1_e2[0]);
            r2_pm[3] <= smul_e(w_dx[0], r1_e2[2]);
            r2_pm[4] <= smul_e(w_dx[0], r1_e2[1]);
            r2_pm[5] <= smul_e(w_dx[1], r1_e2[0]);
            r2_qm[0] <= smul_e(r1_t[1], r1_e1[2]);
            r2_qm[1] <= smul_e(r1_t[2], r1_e1[1]);
            r2_qm[2] <= smul_e(r1_t[2], r1_e1[0]);
            r2_qm[3] <= smul_e(r1_t[0], r1_e1[2]);
            r2_qm[4] <= smul_e(r1_t[0], r1_e1[1]);
            r2_qm[5] <= smul_e(r1_t[1], r1_e1[0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross product differences.
    // ------------------------------------------------------------------
    logic                 r3_v;
    logic [IDW-1:0]       r3_id;
    logic signed [EW-1:0] r3_e1 [0:2];
    logic signed [EW-1:0] r3_e2 [0:2];
    logic signed [EW-1:0] r3_t  [0:2];
    logic signed [XW-1:0] r3_p  [0:2];
    logic signed [XW-1:0] r3_q  [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_id <= r2_id;
            r3_e1 <= r2_e1;
            r3_e2 <= r2_e2;
            r3_t  <= r2_t;
            for (int k = 0; k < 3; k++) begin
                r3_p[k] <= XW'(r2_pm[2*k]) - XW'(r2_pm[2*k + 1]);
                r3_q[k] <= XW'(r2_qm[2*k]) - XW'(r2_qm[2*k + 1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of the four dot products det = E1.P, U = T.P,
    // V = D.Q and W = E2.Q. Each wide cross component is split into a low
    // unsigned slice and a high signed slice.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] w_l [0:3][0:2];
    logic signed [XW-1:0] w_r [0:3][0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_l[0][c] = r3_e1[c];
            w_l[1][c] = r3_t[c];
            w_l[2][c] = w_dx[c];
            w_l[3][c] = r3_e2[c];
            w_r[0][c] = r3_p[c];
            w_r[1][c] = r3_p[c];
            w_r[2][c] = r3_q[c];
            w_r[3][c] = r3_q[c];
        end
    end

    logic                  r4_v;
    logic [IDW-1:0]        r4_id;
    logic signed [PW2-1:0] r4_lo [0:3][0:2];
    logic signed [PW2-1:0] r4_hi [0:3][0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_id <= r3_id;
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r4_lo[k][c] <= smul_h(w_l[k][c], {1'b0, w_r[k][c][LW-1:0]});
                    r4_hi[k][c] <= smul_h(w_l[k][c], w_r[k][c][XW-1:LW]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine the slices of each component product.
    // ------------------------------------------------------------------
    logic                 r5_v;
    logic [IDW-1:0]       r5_id;
    logic signed [DW-1:0] r5_cp [0:3][0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_id <= r4_id;
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r5_cp[k][c] <= (DW'(r4_hi[k][c]) <<< LW) + DW'(r4_lo[k][c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sum the three components of each dot product.
    // Index 0 is det, 1 is U, 2 is V and 3 is W.
    // ------------------------------------------------------------------
    logic                 r6_v;
    logic [IDW-1:0]       r6_id;
    logic signed [DW-1:0] r6_dot [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_id <= r5_id;
            for (int k = 0; k < 4; k++) begin
                r6_dot[k] <= r5_cp[k][0] + r5_cp[k][1] + r5_cp[k][2];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: make det positive by negating all four values when it is negative.
    // ------------------------------------------------------------------
    logic                 r7_v;
    logic [IDW-1:0]       r7_id;
    logic                 r7_nz;
    logic signed [DW-1:0] r7_dot [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_id <= r6_id;
            r7_nz <= (r6_dot[0] != '0);
            for (int k = 0; k < 4; k++) begin
                r7_dot[k] <= r6_dot[0][DW-1] ? -r6_dot[k] : r6_dot[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: barycentric test, and the offset numerator of t:
    // N = W * 2^FRAC + det * 2^(TW-1), so that floor(N / det) is t shifted
    // into the unsigned range.
    // ------------------------------------------------------------------
    logic                 r8_v;
    logic [IDW-1:0]       r8_id;
    logic                 r8_ok;
    logic [DW-1:0]        r8_det;
    logic [DW-1:0]        r8_u;
    logic [DW-1:0]        r8_vv;
    logic signed [NW-1:0] r8_nt;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_id  <= r7_id;
            r8_ok  <= r7_nz && !r7_dot[1][DW-1] && !r7_dot[2][DW-1] &&
                      ((DW+1)'(r7_dot[1]) + (DW+1)'(r7_dot[2]) <= (DW+1)'(r7_dot[0]));
            r8_det <= r7_dot[0];
            r8_u   <= r7_dot[1];
            r8_vv  <= r7_dot[2];
            r8_nt  <= (NW'(r7_dot[3]) <<< FRAC_W) + (NW'(r7_dot[0]) <<< (TW - 1));
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: saturation flags and divider set-up (first divider register).
    // ------------------------------------------------------------------
    t_dv  r_dv  [0:TW];
    logic r_dvv [0:TW];
    t_dv  n_dv0;

    always_comb begin
        n_dv0.id      = r8_id;
        n_dv0.bary_ok = r8_ok;
        n_dv0.sat_lo  = r8_nt[NW-1];
        n_dv0.sat_hi  = (r8_nt >= (NW'(signed'(r8_det)) <<< TW));
        n_dv0.det     = r8_det;
        n_dv0.tr      = RW'(r8_nt[NW-1:TW]);
        n_dv0.tl      = r8_nt[TW-1:0];
        n_dv0.ur      = RW'(r8_u[DW-1:1]);
        n_dv0.ul      = {r8_u[0], {BARY_W{1'b0}}};
        n_dv0.vr      = RW'(r8_vv[DW-1:1]);
        n_dv0.vl      = {r8_vv[0], {BARY_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit of t per stage; u and v finish after UQ stages
    // and are then carried along unchanged.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < TW; g++) begin : g_div
        t_dv   n_dv;
        t_step w_ts;
        t_step w_us;
        t_step w_vs;

        always_comb begin
            w_ts = div_step(r_dv[g].tr, r_dv[g].tl[TW-1], r_dv[g].det);
            w_us = div_step(r_dv[g].ur, r_dv[g].ul[UQ-1], r_dv[g].det);
            w_vs = div_step(r_dv[g].vr, r_dv[g].vl[UQ-1], r_dv[g].det);
            n_dv    = r_dv[g];
            n_dv.tr = w_ts.rem;
            n_dv.tl = {r_dv[g].tl[TW-2:0], w_ts.q};
            if (g < UQ) begin
                n_dv.ur = w_us.rem;
                n_dv.ul = {r_dv[g].ul[UQ-2:0], w_us.q};
                n_dv.vr = w_vs.rem;
                n_dv.vl = {r_dv[g].vl[UQ-2:0], w_vs.q};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[g + 1] <= n_dv;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: undo the offset of t (flip its sign bit), saturate, apply
    // the distance interval and zero the fields of a miss.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] w_tq;
    logic                 w_hit;

    always_comb begin
        if (r_dv[TW].sat_lo) begin
            w_tq = T_MIN;
        end else if (r_dv[TW].sat_hi) begin
            w_tq = T_MAX;
        end else begin
            w_tq = {~r_dv[TW].tl[TW-1], r_dv[TW].tl[TW-2:0]};
        end
        w_hit = r_dv[TW].bary_ok && (w_tq >= TW'(r_tnear)) && (w_tq <= TW'(r_tfar));
    end

    logic [IDW-1:0] r_oid;
    logic           r_ohit;
    logic [TW-1:0]  r_ot;
    logic [UQ-1:0]  r_ou;
    logic [UQ-1:0]  r_ovb;
    logic           r_ov;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oid  <= r_dv[TW].id;
            r_ohit <= w_hit;
            r_ot   <= w_hit ? w_tq : '0;
            r_ou   <= w_hit ? r_dv[TW].ul : '0;
            r_ovb  <= w_hit ? r_dv[TW].vl : '0;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            for (int k = 0; k <= TW; k++) begin
                r_dvv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v     <= i_s_tvalid;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r5_v     <= r4_v;
            r6_v     <= r5_v;
            r7_v     <= r6_v;
            r8_v     <= r7_v;
            r_dvv[0] <= r8_v;
            for (int k = 0; k < TW; k++) begin
                r_dvv[k + 1] <= r_dvv[k];
            end
            r_ov <= r_dvv[TW];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_ohit;
    assign o_m_tdata  = ODATA_W'({r_ovb, r_ou, r_ot, r_oid});

endmodule

// ----- src/rti_chk.sv -----
// Port-level checker for the ray/triangle intersection block, bound to the top level.
module rti_chk
    import rti_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_m_tready,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic [ODATA_W-1:0]   o_m_tdata,
    input logic                 o_m_tuser
);

    // A held result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // The input side is open exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output state");

    // A miss carries zero distance and zero barycentrics.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[IDW+TW+2*UQ-1:IDW] == '0)
        else $error("miss with nonzero fields");

    // A hit has u + v no larger than one.
    a_bary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            ((UQ+1)'(o_m_tdata[IDW+TW +: UQ]) + (UQ+1)'(o_m_tdata[IDW+TW+UQ +: UQ]))
            <= (UQ+1)'(1 << BARY_W))
        else $error("barycentric sum above one");

endmodule

bind ray_triangle_intersect rti_chk u_rti_chk (.*);
